// ===== rtl/des_pkg.sv =====
package des_pkg;

   localparam int BLOCK_W = 64;
   localparam int HALF_W  = 32;
   localparam int SUBKEY_W = 48;
   localparam int CD_W = 28;

   typedef logic [BLOCK_W-1:0] block_type;

   typedef logic [7:0] perm64_type [64];
   typedef logic [7:0] perm48_type [48];
   typedef logic [7:0] perm32_type [32];
   typedef logic [7:0] perm56_type [56];

   localparam perm64_type TAB_IP = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

   localparam perm64_type TAB_FP = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

   localparam perm48_type TAB_E = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
      28,29,30,31,32,1};

   localparam perm32_type TAB_P = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

   localparam perm56_type TAB_PC1 = '{
      57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
      10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
      63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
      14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

   localparam perm48_type TAB_PC2 = '{
      14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
      41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
      46,42,50,36,29,32};

   localparam logic [15:0] ROT_TWO = 16'b0111111011111100; // bit i: round i shifts by 2

   typedef logic [3:0] sbox_row_type [64];
   typedef sbox_row_type sbox_type [8];

   localparam sbox_type TAB_SBOX = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
        0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
        15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
        3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
        13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
        13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
        1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
        13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
        3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
        14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
        11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
        10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
        4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
        13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
        6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
        1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
        2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   // Bit k from the MSB of each result takes table[k]'th bit from the MSB of the source.
   function automatic logic [63:0] perm_ip(input logic [63:0] src);
      logic [63:0] r;
      for (int k = 0; k < 64; k++) r[63-k] = src[64 - 32'(TAB_IP[k])];
      return r;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] src);
      logic [63:0] r;
      for (int k = 0; k < 64; k++) r[63-k] = src[64 - 32'(TAB_FP[k])];
      return r;
   endfunction

   function automatic logic [55:0] perm_pc1(input logic [63:0] src);
      logic [55:0] r;
      for (int k = 0; k < 56; k++) r[55-k] = src[64 - 32'(TAB_PC1[k])];
      return r;
   endfunction

   function automatic logic [47:0] perm_pc2(input logic [55:0] src);
      logic [47:0] r;
      for (int k = 0; k < 48; k++) r[47-k] = src[56 - 32'(TAB_PC2[k])];
      return r;
   endfunction

   function automatic logic [27:0] rotl28(input logic [27:0] v, input logic two);
      return two ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
   endfunction

   // Round function: expand, mix in the subkey, substitute, permute.
   function automatic logic [31:0] feistel_f(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0] six;
      for (int j = 0; j < 48; j++) x[47-j] = r[32 - 32'(TAB_E[j])];
      x = x ^ k;
      for (int b = 0; b < 8; b++) begin
         six = x[47-6*b -: 6];
         s[31-4*b -: 4] = TAB_SBOX[b][{six[5], six[0], six[4:1]}];
      end
      for (int j = 0; j < 32; j++) p[31-j] = s[32 - 32'(TAB_P[j])];
      return p;
   endfunction

endpackage

// ===== rtl/des_block_encrypt.sv =====
// Channel   Dir  Handshake                  Payload
// req_      in   req_tvalid / req_tready    req_tdata  = plaintext[63:0]
// rsp_      out  rsp_tvalid / rsp_tready    rsp_tdata  = ciphertext[63:0]
// csr_      in   csr_wen                    csr_wdata  = cipher_key[63:0]
//
// One word per cycle sustained while rsp_ is not stalled. The accepting edge
// loads the initial permutation and key split stage, then one stage per
// Feistel round, then the output register after the final permutation.
// Each round stage carries its own C/D key halves, so a word keeps the key
// it entered with.
// Reset (synchronous) clears only the valid bits and the key register.
// A stall at rsp_ freezes the whole pipeline; req_tready drops with it, so
// no word is lost or repeated.
module des_block_encrypt #(
   parameter int ROUND_COUNT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,   // [63:0] plaintext
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // [63:0] ciphertext
   input  logic                  csr_wen,
   input  logic [63:0]           csr_wdata
);
   import des_pkg::*;

   localparam int NS = ROUND_COUNT + 1;

   logic [63:0] key_ff;
   logic        adv;

   logic [NS-1:0] vld_ff;
   logic [31:0]   l_ff [NS];
   logic [31:0]   r_ff [NS];
   logic [27:0]   c_ff [NS];
   logic [27:0]   d_ff [NS];
   logic          out_vld_ff;
   logic [63:0]   out_ff;

   // Advance everything whenever the output register is free or being drained.
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) key_ff <= '0;
      else if (csr_wen) key_ff <= csr_wdata;
   end

   // Stage 0: initial permutation and PC-1.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      logic [63:0] ip_in;
      logic [55:0] cd_in;
      ip_in = perm_ip(req_tdata);
      cd_in = perm_pc1(key_ff);
      if (adv) begin
         l_ff[0] <= ip_in[63:32];
         r_ff[0] <= ip_in[31:0];
         c_ff[0] <= cd_in[55:28];
         d_ff[0] <= cd_in[27:0];
      end
   end

   // One Feistel round per stage.
   for (genvar g = 1; g < NS; g++) begin : g_round
      logic [27:0] c_in, d_in;
      logic [31:0] r_in;
      assign c_in = rotl28(c_ff[g-1], ROT_TWO[(g-1) % 16]);
      assign d_in = rotl28(d_ff[g-1], ROT_TWO[(g-1) % 16]);
      assign r_in = l_ff[g-1] ^ feistel_f(r_ff[g-1], perm_pc2({c_in, d_in}));

      always_ff @(posedge clock) begin
         if (reset) vld_ff[g] <= 1'b0;
         else if (adv) vld_ff[g] <= vld_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            l_ff[g] <= r_ff[g-1];
            r_ff[g] <= r_in;
            c_ff[g] <= c_in;
            d_ff[g] <= d_in;
         end
      end
   end

   // Swap halves, final permutation, hold until taken.
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= vld_ff[NS-1];
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= perm_fp({r_ff[NS-1], l_ff[NS-1]});
   end

endmodule

// ===== rtl/des_block_encrypt_checker.sv =====
module des_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed under stall");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input refused with empty output");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word straight after reset");
endmodule

bind des_block_encrypt des_chk u_des_chk (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import des_pkg::*;

   // Expected ciphertext words, oldest first, with the failure tally.
   class cipher_scoreboard;
      block_type pending_cipher[$];
      int        fail_count;

      function void note_plaintext(block_type ct);
         pending_cipher.push_back(ct);
      endfunction

      function void check_ciphertext(block_type got);
         block_type want;
         if (pending_cipher.size() == 0) begin
            $error("unexpected ciphertext word %h", got);
            fail_count++;
         end else begin
            want = pending_cipher.pop_front();
            if (want !== got) begin
               $error("ciphertext: expected %h actual %h", want, got);
               fail_count++;
            end
         end
      endfunction
   endclass

   localparam int LATENCY = 18;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [63:0] plaintext
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [63:0] ciphertext
   logic        csr_wen;
   logic [63:0] csr_wdata;

   cipher_scoreboard board;
   logic [63:0]      key_now;
   bit               calm;     // no idling in the last part of the run
   bit               hold_rsp; // long receiver hold-off requested

   des_block_encrypt uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Pick bits from the MSB side: result bit k (1-based, MSB) is source bit tab[k].
   function automatic logic [63:0] pick_bits(logic [63:0] src, int m, int n,
                                             const ref logic [7:0] tab[]);
      logic [63:0] r;
      r = '0;
      for (int k = 0; k < n; k++) r = {r[62:0], src[m - int'(tab[k])]};
      return r;
   endfunction

   // Full 16-round DES encryption of one block under one key.
   function automatic block_type des_encipher(logic [63:0] key, block_type pt);
      logic [7:0]  t_ip[], t_fp[], t_e[], t_p[], t_pc1[], t_pc2[];
      logic [63:0] cd, blk, ex;
      logic [27:0] c, d;
      logic [31:0] l, r, s, f, tmp;
      logic [47:0] sub;
      logic [5:0]  six;
      int          sh;
      t_ip = new[64]; t_fp = new[64]; t_e = new[48];
      t_p = new[32]; t_pc1 = new[56]; t_pc2 = new[48];
      foreach (t_ip[i]) t_ip[i] = TAB_IP[i];
      foreach (t_fp[i]) t_fp[i] = TAB_FP[i];
      foreach (t_e[i]) t_e[i] = TAB_E[i];
      foreach (t_p[i]) t_p[i] = TAB_P[i];
      foreach (t_pc1[i]) t_pc1[i] = TAB_PC1[i];
      foreach (t_pc2[i]) t_pc2[i] = TAB_PC2[i];
      cd  = pick_bits(key, 64, 56, t_pc1);
      c   = cd[55:28];
      d   = cd[27:0];
      blk = pick_bits(pt, 64, 64, t_ip);
      l   = blk[63:32];
      r   = blk[31:0];
      for (int i = 0; i < 16; i++) begin
         // rounds 1, 2, 9 and 16 shift by one, the rest by two
         sh = (i == 0 || i == 1 || i == 8 || i == 15) ? 1 : 2;
         for (int j = 0; j < sh; j++) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end
         sub = 48'(pick_bits({8'h00, c, d}, 56, 48, t_pc2));
         ex  = pick_bits({32'h0, r}, 32, 48, t_e) ^ {16'h0, sub};
         for (int b = 0; b < 8; b++) begin
            six = ex[47-6*b -: 6];
            s[31-4*b -: 4] = TAB_SBOX[b][{six[5], six[0], six[4:1]}];
         end
         f   = 32'(pick_bits({32'h0, s}, 32, 32, t_p));
         tmp = r;
         r   = l ^ f;
         l   = tmp;
      end
      return pick_bits({r, l}, 64, 64, t_fp);
   endfunction

   // Drop valid and idle at random (one time in four), unless in the calm tail.
   task automatic sender_gap();
      int n;
      n = $urandom_range(1, 5);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Offer one plaintext word and hold it until taken.
   task automatic send_plaintext(block_type pt);
      sender_gap();
      req_tvalid <= 1'b1;
      req_tdata  <= pt;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_plaintext(des_encipher(key_now, pt));
   endtask

   // Drop valid, drain the pipeline, then load a new key.
   task automatic load_key(logic [63:0] key);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_cipher.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= key;
      @(posedge clock);
      csr_wen <= 1'b0;
      key_now = key;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Result side: check on each handshake, advance ready at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_ciphertext(rsp_tdata);
      end
   end

   initial begin : receiver
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 5);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("des_block_encrypt test failed");
      $finish;
   end

   initial begin : stimulus
      logic [63:0] keys[$];
      int          wait_count;
      board      = new();
      calm       = 1'b0;
      hold_rsp   = 1'b0;
      key_now    = '0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_wdata  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset key of zero (a weak key) with extreme blocks.
      send_plaintext('0);
      send_plaintext('1);
      send_plaintext(64'h0123456789ABCDEF);

      // Textbook vector, then parity-only key differences must not matter.
      load_key(64'h133457799BBCDFF1);
      send_plaintext(64'h0123456789ABCDEF);
      send_plaintext(64'h8000000000000001);
      load_key(64'h123456789BBCDFF0 ^ 64'h0101010101010101);
      send_plaintext(64'h0123456789ABCDEF);
      load_key('1);
      send_plaintext('0);
      send_plaintext('1);
      load_key(64'h01FE01FE01FE01FE); // semi-weak key
      send_plaintext(64'hAAAAAAAA55555555);
      send_plaintext(64'h5555555555555555);

      // Pressure: stop the receiver while words keep coming.
      hold_rsp = 1'b1;
      for (int i = 0; i < 40; i++) send_plaintext(rand64());

      // Random phases, each under its own key.
      keys = '{64'h0, 64'hFFFFFFFFFFFFFFFF, rand64(), rand64(), rand64(), rand64()};
      foreach (keys[k]) begin
         load_key(keys[k]);
         for (int i = 0; i < 50; i++) begin
            if (k == keys.size() - 1 && i >= 25) calm = 1'b1;
            send_plaintext(rand64());
         end
      end
      for (int i = 0; i < 40; i++) send_plaintext(rand64());
      req_tvalid <= 1'b0;

      // Drain, then allow the pipeline depth for stray words.
      wait_count = 0;
      while (board.pending_cipher.size() != 0 && wait_count < 10000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (board.fail_count == 0 && board.pending_cipher.size() == 0) begin
         $display("des_block_encrypt test passed");
      end else begin
         $display("des_block_encrypt test failed");
      end
      $finish;
   end

endmodule
